### rtl/rxh_pkg.sv
package rxh_pkg;

  localparam int BYTE_W     = 8;
  localparam int HASH_OUT_W = 16;
  localparam int DEN_W      = 16;

  // Control into the remainder unit
  typedef struct packed {
    logic start;
  } div_ctrl_t;

  // Status back from the remainder unit
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### rtl/rxh_in_if.sv
interface rxh_in_if;
  logic                      valid;
  logic                      ready;
  logic [rxh_pkg::BYTE_W-1:0] data_byte;
  logic                      last_byte;
  logic                      no_byte;

  modport source (output valid, data_byte, last_byte, no_byte, input ready);
  modport sink (input valid, data_byte, last_byte, no_byte, output ready);
endinterface

### rtl/rxh_out_if.sv
interface rxh_out_if;
  logic                          valid;
  logic                          ready;
  logic [rxh_pkg::HASH_OUT_W-1:0] hash_value;
  logic [rxh_pkg::DEN_W-1:0]      hash_mod;
  logic                          divide_error;

  modport source (output valid, hash_value, hash_mod, divide_error, input ready);
  modport sink (input valid, hash_value, hash_mod, divide_error, output ready);
endinterface

### rtl/rxh_divider.sv
module rxh_divider #(
  parameter int DIVIDEND_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rxh_pkg::div_ctrl_t         ctrl,
  input  logic [DIVIDEND_BITS-1:0]   dividend,
  input  logic [rxh_pkg::DEN_W-1:0]  divisor,
  output rxh_pkg::div_stat_t         stat,
  output logic [rxh_pkg::DEN_W-1:0]  remainder
);

  localparam int CNT_W = $clog2(DIVIDEND_BITS + 1);

  logic [DIVIDEND_BITS-1:0]  quo_r, quo_nxt;
  logic [rxh_pkg::DEN_W-1:0] rem_r, rem_nxt;
  logic [rxh_pkg::DEN_W-1:0] den_r;
  logic [CNT_W-1:0]          cnt_r;
  logic                      busy_r;
  logic                      done_r;

  logic [rxh_pkg::DEN_W:0]   trial;
  logic [rxh_pkg::DEN_W:0]   diff;
  logic                      fits;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial   = {rem_r, quo_r[DIVIDEND_BITS-1]};
    diff    = trial - {1'b0, den_r};
    fits    = (trial >= {1'b0, den_r});
    rem_nxt = fits ? diff[rxh_pkg::DEN_W-1:0] : trial[rxh_pkg::DEN_W-1:0];
    quo_nxt = {quo_r[DIVIDEND_BITS-2:0], 1'b0};
  end

  // Control: load on start, count steps, hold done until the next start
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (ctrl.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(DIVIDEND_BITS);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      quo_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign remainder = rem_r;

endmodule

### rtl/rotate_xor_string_hash_mod.sv
// Throughput: a byte beat that does not end a string takes one cycle; ready stays high.
// An end-of-string beat starts the bit-serial remainder unit, one dividend bit at a time,
// and ready stays low until the remainder is done and the result is loaded into the output
// register, which waits while the receiver still holds the previous result beat.
// Synchronous active-low reset clears hash and valid.
module rotate_xor_string_hash_mod #(
  parameter int HASH_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  rxh_in_if.sink                        in_ch,
  rxh_out_if.source                     out_ch,
  input  logic                          cfg_wr_en,
  input  logic [rxh_pkg::DEN_W-1:0]     cfg_wr_data
);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_DIV
  } state_t;

  state_t                         state_r;
  logic [HASH_BITS-1:0]           hash_r;
  logic [rxh_pkg::DEN_W-1:0]      den_r;
  logic [rxh_pkg::HASH_OUT_W-1:0] fin_low_r;
  logic                           den_zero_r;

  logic                           out_valid_r;
  logic [rxh_pkg::HASH_OUT_W-1:0] hash_value_r;
  logic [rxh_pkg::DEN_W-1:0]      hash_mod_r;
  logic                           divide_error_r;

  logic                           in_beat;
  logic                           slot_free;
  logic                           load_out;
  logic [HASH_BITS-1:0]           hash_rot;
  logic [HASH_BITS-1:0]           hash_nxt;

  rxh_pkg::div_ctrl_t             div_ctrl;
  rxh_pkg::div_stat_t             div_stat;
  logic [rxh_pkg::DEN_W-1:0]      div_rem;

  // Rotate left by one and fold in the byte, unless the beat carries none
  always_comb begin
    hash_rot = {hash_r[HASH_BITS-2:0], hash_r[HASH_BITS-1]}
               ^ HASH_BITS'(in_ch.data_byte);
    hash_nxt = in_ch.no_byte ? hash_r : hash_rot;
  end

  assign in_ch.ready   = (state_r == ST_IDLE);
  assign in_beat       = in_ch.valid && in_ch.ready;
  assign slot_free     = !out_valid_r || out_ch.ready;
  assign load_out      = (state_r == ST_DIV) && div_stat.done && slot_free;
  assign div_ctrl.start = in_beat && in_ch.last_byte;

  rxh_divider #(
    .DIVIDEND_BITS (HASH_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (div_ctrl),
    .dividend  (hash_nxt),
    .divisor   (den_r),
    .stat      (div_stat),
    .remainder (div_rem)
  );

  // Denominator register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      den_r <= rxh_pkg::DEN_W'(1);
    end else if (cfg_wr_en) begin
      den_r <= cfg_wr_data;
    end
  end

  // Sequencer, running hash and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      hash_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_beat) begin
            if (in_ch.last_byte) begin
              hash_r  <= '0;
              state_r <= ST_DIV;
            end else begin
              hash_r <= hash_nxt;
            end
          end
        end
        ST_DIV: begin
          if (load_out) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase

      // Drop a taken result, replace it when the remainder is ready
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload: snapshot the finished hash, then the result fields
  always_ff @(posedge clk) begin
    if (div_ctrl.start) begin
      fin_low_r  <= rxh_pkg::HASH_OUT_W'(hash_nxt);
      den_zero_r <= (den_r == '0);
    end
    if (load_out) begin
      hash_value_r   <= fin_low_r;
      hash_mod_r     <= den_zero_r ? '0 : div_rem;
      divide_error_r <= den_zero_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.hash_value   = hash_value_r;
  assign out_ch.hash_mod     = hash_mod_r;
  assign out_ch.divide_error = divide_error_r;

`ifndef SYNTH
  // While waiting on the remainder, the unit must be running or finished
  a_div_alive: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (div_stat.busy || div_stat.done))
    else $error("remainder unit idle while sequencer waits");

  // A zero denominator result carries a zero modulo
  a_zero_den: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && divide_error_r) |-> (hash_mod_r == '0))
    else $error("divide error with nonzero modulo");

  // The running hash clears after an end-of-string beat
  a_hash_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat && in_ch.last_byte) |=> (hash_r == '0))
    else $error("running hash not cleared at end of string");
`endif

endmodule

### tb/rotate_xor_string_hash_mod_tb.sv
`timescale 1ns / 100ps

module rotate_xor_string_hash_mod_tb;

  localparam int HASH_W = 16;
  localparam int SETTLE_CYCLES = HASH_W + 8;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic [rxh_pkg::BYTE_W-1:0] data_byte;
    logic                       last_byte;
    logic                       no_byte;
  } str_beat_t;

  typedef struct {
    logic [rxh_pkg::HASH_OUT_W-1:0] hash_value;
    logic [rxh_pkg::DEN_W-1:0]      hash_mod;
    logic                           divide_error;
  } hash_result_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [rxh_pkg::DEN_W-1:0] cfg_wr_data;

  rxh_in_if  in_ch ();
  rxh_out_if out_ch ();

  rotate_xor_string_hash_mod #(
    .HASH_BITS(HASH_W)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Beats waiting to be sent and hash results waiting to arrive
  str_beat_t    beat_queue[$];
  hash_result_t hash_expect[$];

  // Shadow of the block's state and register
  logic [HASH_W-1:0]         shadow_hash;
  logic [rxh_pkg::DEN_W-1:0] bucket_count;

  int errors;
  int beats_sent;
  int results_seen;
  int den_settings;

  // Sender and receiver pacing
  bit in_fire;
  bit gapless;
  int burst_left;
  int gap_left;
  bit rx_always;
  bit rx_dense;
  bit holdoff_req;
  int holdoff_left;
  bit [31:0] rx_pattern;
  bit [4:0] rx_pos;

  // Fold one accepted beat into the shadow hash; queue a result on string end
  task automatic absorb_beat(input logic [rxh_pkg::BYTE_W-1:0] b, input logic last,
                             input logic none);
    hash_result_t r;
    if (!none) begin
      shadow_hash = {shadow_hash[HASH_W-2:0], shadow_hash[HASH_W-1]} ^ HASH_W'(b);
    end
    if (last) begin
      r.hash_value = shadow_hash[rxh_pkg::HASH_OUT_W-1:0];
      if (bucket_count == '0) begin
        r.hash_mod = '0;
        r.divide_error = 1'b1;
      end else begin
        r.hash_mod = rxh_pkg::DEN_W'(shadow_hash % bucket_count);
        r.divide_error = 1'b0;
      end
      hash_expect.push_back(r);
      shadow_hash = '0;
    end
  endtask

  task automatic push_beat(input logic [rxh_pkg::BYTE_W-1:0] b, input logic last,
                           input logic none);
    str_beat_t it;
    it.data_byte = b;
    it.last_byte = last;
    it.no_byte = none;
    beat_queue.push_back(it);
  endtask

  // Mostly short strings, a few long ones; some empty beats mixed in
  task automatic queue_random_string(output int n);
    int len;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 6);
    n = 0;
    for (int k = 0; k < len; k++) begin
      push_beat(rxh_pkg::BYTE_W'($urandom_range(0, 255)), 1'b0, $urandom_range(0, 7) == 0);
      n++;
    end
    push_beat(rxh_pkg::BYTE_W'($urandom_range(0, 255)), 1'b1, $urandom_range(0, 3) == 0);
    n++;
  endtask

  task automatic write_denominator(input logic [rxh_pkg::DEN_W-1:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    bucket_count = v;
    den_settings++;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Hold until every beat is sent and every result is back, then let the block settle
  task automatic wait_drained();
    while (beat_queue.size() != 0 || hash_expect.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_random_phase(input logic [rxh_pkg::DEN_W-1:0] den, input int n_beats,
                                  input bit no_gap, input bit rx_all, input bit rx_many,
                                  input bit long_hold);
    int n;
    int added;
    write_denominator(den);
    gapless = no_gap;
    rx_always = rx_all;
    rx_dense = rx_many;
    if (long_hold) holdoff_req = 1'b1;
    added = 0;
    while (added < n_beats) begin
      queue_random_string(n);
      added += n;
    end
    wait_drained();
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Known values on every input from time zero
  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;
    in_ch.no_byte = 1'b0;
    out_ch.ready = 1'b0;
  end

  // Record accepted input beats and advance the shadow model
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      absorb_beat(in_ch.data_byte, in_ch.last_byte, in_ch.no_byte);
      void'(beat_queue.pop_front());
      beats_sent++;
      in_fire = 1'b1;
    end
  end

  // Driver: offer beats in bursts, hold a beat until taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_fire) begin
      // hold the current beat
    end else begin
      in_fire = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (beat_queue.size() > 0) begin
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= beat_queue[0].data_byte;
        in_ch.last_byte <= beat_queue[0].last_byte;
        in_ch.no_byte <= beat_queue[0].no_byte;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = gapless ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: always ready, or stall on a reloaded bit pattern, or hold off for a long stretch
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (holdoff_req) begin
        holdoff_left = HOLDOFF_CYCLES;
        holdoff_req = 1'b0;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (rx_pos == 0) rx_pattern = rx_dense ? ($urandom() | $urandom()) : $urandom();
        out_ch.ready <= rx_always || rx_pattern[rx_pos];
        rx_pos++;
      end
    end
  end

  // Monitor: compare each result beat with the oldest expected hash
  always @(posedge clk) begin
    hash_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (hash_expect.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result hash=%h mod=%h err=%b", $realtime,
                   out_ch.hash_value, out_ch.hash_mod, out_ch.divide_error);
      end else begin
        want = hash_expect.pop_front();
        if (out_ch.hash_value !== want.hash_value || out_ch.hash_mod !== want.hash_mod ||
            out_ch.divide_error !== want.divide_error) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: mismatch exp hash=%h mod=%h err=%b got hash=%h mod=%h err=%b",
                     $realtime, want.hash_value, want.hash_mod, want.divide_error,
                     out_ch.hash_value, out_ch.hash_mod, out_ch.divide_error);
        end
      end
    end
  end

  // Main sequence
  initial begin
    shadow_hash = '0;
    bucket_count = 1;
    errors = 0;
    beats_sent = 0;
    results_seen = 0;
    den_settings = 0;
    in_fire = 1'b0;
    gapless = 1'b0;
    burst_left = 0;
    gap_left = 0;
    rx_always = 1'b0;
    rx_dense = 1'b1;
    holdoff_req = 1'b0;
    holdoff_left = 0;
    rx_pattern = '0;
    rx_pos = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed strings under the reset denominator
    push_beat(8'hA5, 1'b1, 1'b1);              // empty string, byte ignored
    push_beat(8'h00, 1'b1, 1'b0);
    push_beat(8'hFF, 1'b1, 1'b0);
    push_beat(8'h80, 1'b0, 1'b0);
    push_beat(8'h01, 1'b0, 1'b0);
    push_beat(8'h5A, 1'b0, 1'b1);              // no byte, not last: nothing changes
    push_beat(8'hFF, 1'b0, 1'b0);
    push_beat(8'h00, 1'b1, 1'b1);              // end without byte mid-string
    for (int k = 0; k < 15; k++) push_beat(8'hFF, 1'b0, 1'b0);
    push_beat(8'hFF, 1'b1, 1'b0);              // rotation wraps the top bit around
    wait_drained();

    // Random strings across denominator settings and pacing modes
    run_random_phase(16'h0000, 250, 1'b0, 1'b0, 1'b1, 1'b0);
    run_random_phase(16'hFFFF, 250, 1'b1, 1'b1, 1'b1, 1'b0);
    run_random_phase(16'h0001, 250, 1'b0, 1'b0, 1'b1, 1'b1);
    run_random_phase(16'h8000, 250, 1'b0, 1'b0, 1'b0, 1'b0);
    run_random_phase(16'h0003, 250, 1'b1, 1'b0, 1'b0, 1'b0);
    run_random_phase(16'h00FF, 250, 1'b0, 1'b1, 1'b1, 1'b0);
    run_random_phase(rxh_pkg::DEN_W'($urandom_range(2, 65535)), 250,
                     1'b0, 1'b0, 1'b1, 1'b0);
    run_random_phase(rxh_pkg::DEN_W'($urandom_range(2, 20)), 250,
                     1'b1, 1'b0, 1'b1, 1'b0);

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Run covered %0d input beats and %0d hash results over %0d denominator settings,",
             beats_sent, results_seen, den_settings + 1);
    $display("including a zero and a full-range denominator, empty strings and a long stall.");
    if (errors == 0 && hash_expect.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("Timeout with %0d results still expected", hash_expect.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
